// ===== rtl/mavg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavg_pkg
// Shared widths, constants and controller/datapath interface types for the
// moving average filter.
// ----------------------------------------------------------------------------
package mavg_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int WIN_W        = 10;
    localparam int WINDOW_RESET = 20;

    typedef struct packed {
        logic capture;   // latch incoming sample, start store read
        logic update;    // write store, update running sum, load divider
        logic div_step;  // one restoring divide step
        logic out_load;  // move quotient into output register
    } mavg_cmd_t;

    typedef struct packed {
        logic out_free;  // output register empty or being drained
    } mavg_status_t;

endpackage

// ===== rtl/mavg_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavg_ram
// Generic single-port RAM, one write or read address per cycle, registered
// read data (read-before-write).
// ----------------------------------------------------------------------------
module mavg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mavg_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavg_ctrl
// Sequencer: accept, store update, iterative divide, output hand-off.
// ----------------------------------------------------------------------------
module mavg_ctrl #(
    parameter int DIV_STEPS = 26
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  mavg_pkg::mavg_status_t  status,
    output mavg_pkg::mavg_cmd_t     cmd
);
    import mavg_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_UPDATE = 2'd1;
    localparam logic [1:0] ST_DIV    = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                cnt_next   = CNT_W'(DIV_STEPS - 1);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== rtl/mavg_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavg_datapath
// Window register, ring store, running sum, restoring divider and output
// register.
// ----------------------------------------------------------------------------
module mavg_datapath #(
    parameter int MAX_WINDOW = 512,
    parameter int SUM_W      = 26
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [mavg_pkg::WIN_W-1:0]     cfg_wdata,
    input  logic [mavg_pkg::SAMPLE_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mavg_pkg::SAMPLE_W-1:0]  m_tdata,
    input  mavg_pkg::mavg_cmd_t            cmd,
    output mavg_pkg::mavg_status_t         status
);
    import mavg_pkg::*;

    localparam int PTR_W = $clog2(MAX_WINDOW);
    localparam int CMP_W = ((PTR_W > WIN_W) ? PTR_W : WIN_W) + 1;
    localparam int REM_W = WIN_W + 1;

    function automatic logic [WIN_W-1:0] clamp_window(input logic [WIN_W-1:0] v);
        logic [WIN_W-1:0] r;
        r = v;
        if (r == '0) begin
            r = WIN_W'(1);
        end
        if (CMP_W'(r) > CMP_W'(MAX_WINDOW)) begin
            r = WIN_W'(MAX_WINDOW);
        end
        return r;
    endfunction

    logic [WIN_W-1:0]    window_reg;
    logic [PTR_W-1:0]    ptr_reg;
    logic                wrapped_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [SUM_W-1:0]    quo_reg;
    logic                neg_reg;
    logic                out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] out_data_reg;

    logic [SAMPLE_W-1:0]     rd_data;
    logic signed [SAMPLE_W-1:0] old_sample;
    logic signed [SUM_W-1:0] sum_next;
    logic [SUM_W-1:0]        sum_mag;
    logic [CMP_W-1:0]        ptr_inc;
    logic                    ptr_wrap;
    logic [REM_W-1:0]        rem_shift;
    logic [REM_W:0]          trial;
    logic [SAMPLE_W-1:0]     quo_low;

    mavg_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WINDOW)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.update),
        .addr  (ptr_reg),
        .wdata (sample_reg),
        .rdata (rd_data)
    );

    assign old_sample = wrapped_reg ? $signed(rd_data) : '0;
    assign sum_next   = sum_reg - SUM_W'(old_sample) + SUM_W'($signed(sample_reg));
    assign sum_mag    = sum_next[SUM_W-1] ? SUM_W'(-sum_next) : SUM_W'(sum_next);
    assign ptr_inc    = CMP_W'(ptr_reg) + CMP_W'(1);
    assign ptr_wrap   = ptr_inc >= CMP_W'(window_reg);

    assign rem_shift  = {rem_reg[REM_W-2:0], quo_reg[SUM_W-1]};
    assign trial      = {1'b0, rem_shift} - {2'b00, window_reg};
    assign quo_low    = quo_reg[SAMPLE_W-1:0];

    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_data_reg;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg    <= clamp_window(WIN_W'(WINDOW_RESET));
            ptr_reg       <= '0;
            wrapped_reg   <= 1'b0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                window_reg  <= clamp_window(cfg_wdata);
                ptr_reg     <= '0;
                wrapped_reg <= 1'b0;
                sum_reg     <= '0;
            end else if (cmd.update) begin
                sum_reg <= sum_next;
                if (ptr_wrap) begin
                    ptr_reg     <= '0;
                    wrapped_reg <= 1'b1;
                end else begin
                    ptr_reg <= ptr_inc[PTR_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            sample_reg <= s_tdata;
        end
        if (cmd.update) begin
            rem_reg <= '0;
            quo_reg <= sum_mag;
            neg_reg <= sum_next[SUM_W-1];
        end else if (cmd.div_step) begin
            if (!trial[REM_W]) begin
                rem_reg <= trial[REM_W-1:0];
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_shift;
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
            end
        end
        if (cmd.out_load) begin
            out_data_reg <= neg_reg ? SAMPLE_W'(-quo_low) : quo_low;
        end
    end

endmodule

// ===== rtl/moving_average_filter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moving_average_filter_core
// Boxcar moving average over a configurable window of signed 16-bit samples.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one sample request per item, s_tdata = sample (signed 16).
//   m_ channel: one mean request per sample, m_tdata = mean (signed 16),
//     window sum / window length truncated toward zero.
//   cfg_we/cfg_wdata: window length write (0 taken as 1, values above
//     MAX_WINDOW saturate); also empties the window. Write only when idle.
// Timing: each sample passes the store read/write step, the bit-per-cycle
//   restoring divider and then the output register before m_tvalid. The
//   next sample is accepted only after the mean enters the output register,
//   so the core works on one sample at a time.
// Stall: the output register holds the mean while m_tready is low; a new
//   sample is still accepted and computed, then waits for the register.
// Reset: window length 20, running sum and write pointer zero. Store entries
//   not written since reset or a window write read as zero (wrap flag), so no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module moving_average_filter_core #(
    parameter int MAX_WINDOW = 512
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [mavg_pkg::WIN_W-1:0]    cfg_wdata,    // [9:0] window_length
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mavg_pkg::SAMPLE_W-1:0] s_tdata,      // [15:0] sample
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mavg_pkg::SAMPLE_W-1:0] m_tdata       // [15:0] mean
);
    import mavg_pkg::*;

    localparam int WIN_MAX = (1 << WIN_W) - 1;
    localparam int EFF_MAX = (MAX_WINDOW < WIN_MAX) ? MAX_WINDOW : WIN_MAX;
    localparam int SUM_W   = SAMPLE_W + $clog2(EFF_MAX) + 1;

    mavg_cmd_t    cmd;
    mavg_status_t status;

    mavg_ctrl #(
        .DIV_STEPS (SUM_W)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mavg_datapath #(
        .MAX_WINDOW (MAX_WINDOW),
        .SUM_W      (SUM_W)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ===== tb/tb_moving_average_filter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_moving_average_filter_core
// Self-checking bench for the boxcar moving average core. A directed table
// after reset covers the sample extremes, truncation toward zero and the ring
// wrap. Random phases follow under several window lengths, including 0, the
// full window and saturated writes. Both stream sides idle at random. Typed
// rows check table means, others a bench-side model of ring, pointer and sum.
// ----------------------------------------------------------------------------
module tb_moving_average_filter_core;

    import mavg_pkg::SAMPLE_W;
    import mavg_pkg::WIN_W;
    import mavg_pkg::WINDOW_RESET;

    localparam int MAX_WIN   = 512;
    localparam int SETTLE    = 40;
    localparam int DRAIN_MAX = 5000;
    localparam int N_DIR     = 24;
    localparam int MAX_SHOWN = 200;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                typed;
        logic [SAMPLE_W-1:0] mean;
    } dir_row_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_we;
    logic [WIN_W-1:0]    cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [SAMPLE_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [SAMPLE_W-1:0] m_tdata;

    logic signed [SAMPLE_W-1:0] window_ring [MAX_WIN];
    int                         wr_slot;
    int                         win_sum;
    int                         win_len;
    logic [SAMPLE_W-1:0]        mean_q [$];
    dir_row_t                   dir_tab [N_DIR];
    int                         errors;
    bit                         s_burst;
    bit                         m_burst;

    moving_average_filter_core #(
        .MAX_WINDOW(MAX_WIN)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic report_fault(input string msg);
        errors++;
        if (errors <= MAX_SHOWN) begin
            $display("ERROR %0t: %s", $time, msg);
        end
    endtask

    function automatic int clamp_len(input logic [WIN_W-1:0] v);
        if (v == '0) begin
            return 1;
        end
        if (int'(v) > MAX_WIN) begin
            return MAX_WIN;
        end
        return int'(v);
    endfunction

    function automatic void clear_ring();
        for (int i = 0; i < MAX_WIN; i++) begin
            window_ring[i] = '0;
        end
        wr_slot = 0;
        win_sum = 0;
    endfunction

    // old entry leaves the sum, new one enters, mean truncates toward zero
    function automatic logic [SAMPLE_W-1:0] advance_mean(input logic [SAMPLE_W-1:0] v);
        int slot;
        int q;
        slot = wr_slot;
        if (slot >= win_len) begin
            slot = 0;
        end
        win_sum = win_sum - int'(window_ring[slot]) + int'($signed(v));
        window_ring[slot] = $signed(v);
        slot++;
        if (slot >= win_len) begin
            slot = 0;
        end
        wr_slot = slot;
        q = win_sum / win_len;
        return q[SAMPLE_W-1:0];
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'(int'($urandom_range(0, 6)) - 3);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] v, input bit typed,
                               input logic [SAMPLE_W-1:0] typed_mean);
        int unsigned gap;
        logic [SAMPLE_W-1:0] m;
        if ($urandom_range(0, 31) == 0) begin
            s_burst = !s_burst;
        end
        gap = s_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
        m = advance_mean(v);
        mean_q.push_back(typed ? typed_mean : m);
    endtask

    // block must be idle: all means back, then latency margin
    task automatic write_window(input logic [WIN_W-1:0] v);
        s_tvalid <= 1'b0;
        while (mean_q.size() > 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        win_len = clamp_len(v);
        clear_ring();
    endtask

    task automatic run_phase(input logic [WIN_W-1:0] v, input int n, input bit fill);
        write_window(v);
        s_burst = ($urandom_range(0, 3) == 0);
        m_burst = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n; i++) begin
            if (fill && i < MAX_WIN) begin
                send_sample(16'h8000, 1'b0, '0);
            end else if (fill) begin
                send_sample(16'h7FFF, 1'b0, '0);
            end else begin
                send_sample(rand_sample(), 1'b0, '0);
            end
        end
    endtask

    initial begin
        int unsigned stall;
        m_tready <= 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 31) == 0) begin
                m_burst = !m_burst;
            end
            stall = m_burst ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            if (mean_q.size() == 0) begin
                report_fault($sformatf("mean %h with no request pending", m_tdata));
            end else if (m_tdata !== mean_q[0]) begin
                report_fault($sformatf("mean exp %h got %h", mean_q[0], m_tdata));
                void'(mean_q.pop_front());
            end else begin
                void'(mean_q.pop_front());
            end
        end
    end

    initial begin
        int drain;
        errors    = 0;
        s_burst   = 1'b0;
        m_burst   = 1'b0;
        win_len   = WINDOW_RESET;
        clear_ring();
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;

        // window 20 after reset; last rows wrap onto the first slots
        dir_tab[0]  = '{16'h7FFF, 1'b1, 16'h0666};
        dir_tab[1]  = '{16'h8000, 1'b1, 16'h0000};  // sum -1 truncates to 0
        dir_tab[2]  = '{16'h8000, 1'b1, 16'hF99A};
        dir_tab[3]  = '{16'h0000, 1'b1, 16'hF99A};
        dir_tab[4]  = '{16'h0001, 1'b0, 16'h0000};
        dir_tab[5]  = '{16'hFFFF, 1'b0, 16'h0000};
        dir_tab[6]  = '{16'h5555, 1'b0, 16'h0000};
        dir_tab[7]  = '{16'hAAAA, 1'b0, 16'h0000};
        dir_tab[8]  = '{16'h00FF, 1'b0, 16'h0000};
        dir_tab[9]  = '{16'hFF00, 1'b0, 16'h0000};
        dir_tab[10] = '{16'h7FFE, 1'b0, 16'h0000};
        dir_tab[11] = '{16'h8001, 1'b0, 16'h0000};
        dir_tab[12] = '{16'h0014, 1'b0, 16'h0000};
        dir_tab[13] = '{16'hFFEC, 1'b0, 16'h0000};
        dir_tab[14] = '{16'h7FFF, 1'b0, 16'h0000};
        dir_tab[15] = '{16'h7FFF, 1'b0, 16'h0000};
        dir_tab[16] = '{16'h8000, 1'b0, 16'h0000};
        dir_tab[17] = '{16'h1234, 1'b0, 16'h0000};
        dir_tab[18] = '{16'hEDCB, 1'b0, 16'h0000};
        dir_tab[19] = '{16'h0F0F, 1'b0, 16'h0000};
        dir_tab[20] = '{16'h8000, 1'b0, 16'h0000};
        dir_tab[21] = '{16'h7FFF, 1'b0, 16'h0000};
        dir_tab[22] = '{16'h8000, 1'b0, 16'h0000};
        dir_tab[23] = '{16'h0000, 1'b0, 16'h0000};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIR; i++) begin
            send_sample(dir_tab[i].sample, dir_tab[i].typed, dir_tab[i].mean);
        end

        run_phase(10'd0,    30,  1'b0);    // zero taken as one
        run_phase(10'd1,    20,  1'b0);
        run_phase(10'd2,    30,  1'b0);
        run_phase(10'd1023, 515, 1'b1);    // saturates to full window
        run_phase(10'd513,  20,  1'b0);
        run_phase(10'd512,  20,  1'b0);
        run_phase(10'd3,    20,  1'b0);
        run_phase(10'd19,   30,  1'b0);
        run_phase(10'd300,  40,  1'b0);
        run_phase(10'($urandom_range(1, 1023)), 30, 1'b0);
        run_phase(10'($urandom_range(1, 40)),   40, 1'b0);

        s_tvalid <= 1'b0;
        drain = 0;
        while (mean_q.size() > 0 && drain < DRAIN_MAX) begin
            @(posedge aclk);
            drain++;
        end
        if (mean_q.size() > 0) begin
            report_fault($sformatf("%0d means never returned", mean_q.size()));
        end
        repeat (SETTLE) @(posedge aclk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mavg_pkg.sv
rtl/mavg_ram.sv
rtl/mavg_ctrl.sv
rtl/mavg_datapath.sv
rtl/moving_average_filter_core.sv
tb/tb_moving_average_filter_core.sv
